[rtl/tnrp_pkg.sv]
`timescale 1ns / 1ps

package tnrp_pkg;

  // default limits on the sized policy and name
  localparam int unsigned POLICY_MAX_DEF = 64;
  localparam int unsigned NAME_MAX_DEF   = 64;

  // largest response length that the byte count follows
  localparam int unsigned MAX_RESPONSE_BYTES = 4096;

  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned COUNT_CAP = (MAX_RESPONSE_BYTES < 8191) ? MAX_RESPONSE_BYTES : 8191;

  // word queue of the front, ahead of the parser
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [3:0] {
    FK_TAG       = 4'd0,
    FK_PARAMSIZE = 4'd1,
    FK_RC        = 4'd2,
    FK_PUBSIZE   = 4'd3,
    FK_INDEX     = 4'd4,
    FK_ALG       = 4'd5,
    FK_ATTRS     = 4'd6,
    FK_POLSIZE   = 4'd7,
    FK_POLBYTE   = 4'd8,
    FK_DATASIZE  = 4'd9,
    FK_NAMESIZE  = 4'd10,
    FK_NAMEBYTE  = 4'd11
  } fkind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_POL_LONG  = 3'd2,
    ST_NAME_LONG = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_t;

  // one queued input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } qword_t;

  // one result word
  typedef struct packed {
    fkind_t               field_kind;
    logic [31:0]          field_value;
    logic                 final_res;
    status_t              status;
    logic [COUNT_W-1:0]   consumed;
  } res_t;

endpackage

[rtl/tnrp_if.sv]
`timescale 1ns / 1ps

// response byte channel
interface tnrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// parsed field channel
interface tnrp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [31:0] field_value;
  logic        final_res;
  logic [2:0]  status;
  logic [12:0] consumed;

  modport source (output valid, output field_kind, output field_value, output final_res,
                  output status, output consumed, input ready);
  modport sink (input valid, input field_kind, input field_value, input final_res,
                input status, input consumed, output ready);
endinterface

[rtl/tnrp_front.sv]
`timescale 1ns / 1ps

module tnrp_front import tnrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  qword_t     in_word,
  output logic       head_valid,
  output qword_t     head_word,
  input  logic       head_pop
);

  qword_t             ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push;

  // accept while a slot is free
  assign in_ready   = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != '0);
  assign head_word  = ent_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (head_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !head_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && head_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/tnrp_parser.sv]
`timescale 1ns / 1ps

module tnrp_parser import tnrp_pkg::*; #(
  parameter int unsigned POLICY_MAX = POLICY_MAX_DEF,
  parameter int unsigned NAME_MAX   = NAME_MAX_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   head_valid,
  input  qword_t head_word,
  output logic   head_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res
);

  localparam int unsigned SIZED_MAX = (POLICY_MAX > NAME_MAX) ? POLICY_MAX : NAME_MAX;
  localparam int unsigned SIZED_W   = $clog2(SIZED_MAX + 1);

  typedef enum logic [12:0] {
    PH_TAG      = 13'b0000000000001,
    PH_PSIZE    = 13'b0000000000010,
    PH_RC       = 13'b0000000000100,
    PH_PUBSZ    = 13'b0000000001000,
    PH_INDEX    = 13'b0000000010000,
    PH_ALG      = 13'b0000000100000,
    PH_ATTRS    = 13'b0000001000000,
    PH_POLSZ    = 13'b0000010000000,
    PH_POLBYTE  = 13'b0000100000000,
    PH_DATASZ   = 13'b0001000000000,
    PH_SKIP     = 13'b0010000000000,
    PH_NAMESZ   = 13'b0100000000000,
    PH_NAMEBYTE = 13'b1000000000000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [SIZED_W-1:0] sz_r, sz_nxt;
  logic [15:0]        pbl_r, pbl_nxt;
  logic [COUNT_W-1:0] bc_r, bc_nxt;
  logic               fin_r, fin_nxt;
  logic               out_valid_r;
  res_t               res_r;

  logic               take;
  logic [7:0]         d;
  logic               last;
  logic [COUNT_W-1:0] bc_inc;
  logic [15:0]        pbl_dec;
  logic [SIZED_W-1:0] sz_dec;
  logic [31:0]        acc_new;
  logic [15:0]        val16;
  logic [1:0]         idx_last;
  logic               in_public;
  logic               fld_done;
  logic               emit, done, res_any;
  fkind_t             kind;
  logic [31:0]        val;
  status_t            status;

  // take a word whenever the output register is free or drains
  assign take      = head_valid && (!out_valid_r || out_ready);
  assign head_pop  = take;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign d        = head_word.data_byte;
  assign last     = head_word.last_byte;
  assign bc_inc   = (bc_r < COUNT_W'(COUNT_CAP)) ? bc_r + 1'b1 : bc_r;
  assign pbl_dec  = (pbl_r != '0) ? pbl_r - 1'b1 : pbl_r;
  assign sz_dec   = (sz_r != '0) ? sz_r - 1'b1 : sz_r;
  assign acc_new  = {acc_r[23:0], d};
  assign val16    = acc_new[15:0];
  assign fld_done = (idx_r == idx_last);

  // last byte index of each multi-byte field
  always_comb begin
    unique case (phase_r)
      PH_PSIZE, PH_RC, PH_INDEX, PH_ATTRS: idx_last = 2'd3;
      default:                             idx_last = 2'd1;
    endcase
  end

  assign in_public = (phase_r == PH_INDEX) || (phase_r == PH_ALG) || (phase_r == PH_ATTRS) ||
                     (phase_r == PH_POLSZ) || (phase_r == PH_DATASZ);

  // parse step for the head word
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    sz_nxt    = sz_r;
    pbl_nxt   = pbl_r;
    bc_nxt    = bc_inc;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    done      = 1'b0;
    kind      = FK_TAG;
    val       = '0;
    status    = ST_OK;

    if (fin_r) begin
      bc_nxt = bc_r;
    end else if ((phase_r == PH_POLBYTE) || (phase_r == PH_NAMEBYTE)) begin
      emit   = 1'b1;
      kind   = (phase_r == PH_POLBYTE) ? FK_POLBYTE : FK_NAMEBYTE;
      val    = {24'd0, d};
      sz_nxt = sz_dec;
      if (phase_r == PH_POLBYTE) begin
        pbl_nxt = pbl_dec;
      end
      if (sz_dec == '0) begin
        if (phase_r == PH_POLBYTE) begin
          phase_nxt = PH_DATASZ;
        end else begin
          done = 1'b1;
        end
      end
    end else if (phase_r == PH_SKIP) begin
      pbl_nxt = pbl_dec;
      if (pbl_dec == '0) begin
        phase_nxt = PH_NAMESZ;
      end
    end else if (in_public && (pbl_r == '0)) begin
      done   = 1'b1;
      status = ST_OVERRUN;
    end else begin
      if (in_public) begin
        pbl_nxt = pbl_dec;
      end
      acc_nxt = acc_new;
      idx_nxt = idx_r + 1'b1;
      if (fld_done) begin
        emit    = 1'b1;
        val     = acc_new;
        acc_nxt = '0;
        idx_nxt = '0;
        unique case (phase_r)
          PH_TAG: begin
            kind      = FK_TAG;
            phase_nxt = PH_PSIZE;
          end
          PH_PSIZE: begin
            kind      = FK_PARAMSIZE;
            phase_nxt = PH_RC;
          end
          PH_RC: begin
            kind = FK_RC;
            if (acc_new != '0) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_PUBSZ;
            end
          end
          PH_PUBSZ: begin
            kind      = FK_PUBSIZE;
            pbl_nxt   = val16;
            phase_nxt = (val16 == '0) ? PH_NAMESZ : PH_INDEX;
          end
          PH_INDEX: begin
            kind      = FK_INDEX;
            phase_nxt = PH_ALG;
          end
          PH_ALG: begin
            kind      = FK_ALG;
            phase_nxt = PH_ATTRS;
          end
          PH_ATTRS: begin
            kind      = FK_ATTRS;
            phase_nxt = PH_POLSZ;
          end
          PH_POLSZ: begin
            kind = FK_POLSIZE;
            if (val16 > pbl_dec) begin
              done   = 1'b1;
              status = ST_OVERRUN;
            end else if (val16 > 16'(POLICY_MAX)) begin
              done   = 1'b1;
              status = ST_POL_LONG;
            end else begin
              sz_nxt    = val16[SIZED_W-1:0];
              phase_nxt = (val16 == '0) ? PH_DATASZ : PH_POLBYTE;
            end
          end
          PH_DATASZ: begin
            kind      = FK_DATASIZE;
            phase_nxt = (pbl_dec == '0) ? PH_NAMESZ : PH_SKIP;
          end
          PH_NAMESZ: begin
            kind = FK_NAMESIZE;
            if (val16 > 16'(NAME_MAX)) begin
              done   = 1'b1;
              status = ST_NAME_LONG;
            end else if (val16 == '0) begin
              done = 1'b1;
            end else begin
              sz_nxt    = val16[SIZED_W-1:0];
              phase_nxt = PH_NAMEBYTE;
            end
          end
          default: begin
            phase_nxt = PH_TAG;
          end
        endcase
      end
    end

    // an unfinished parse on the final byte is truncated
    if (!fin_r && !done && last) begin
      done   = 1'b1;
      status = ST_TRUNCATED;
    end

    // final byte always rearms for the next response
    if (last) begin
      phase_nxt = PH_TAG;
      idx_nxt   = '0;
      acc_nxt   = '0;
      sz_nxt    = '0;
      pbl_nxt   = '0;
      bc_nxt    = '0;
      fin_nxt   = 1'b0;
    end else if (done) begin
      fin_nxt = 1'b1;
    end
  end

  assign res_any = emit || done;

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      idx_r   <= '0;
      acc_r   <= '0;
      sz_r    <= '0;
      pbl_r   <= '0;
      bc_r    <= '0;
      fin_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      sz_r    <= sz_nxt;
      pbl_r   <= pbl_nxt;
      bc_r    <= bc_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= take && res_any;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (take && res_any) begin
      res_r.field_kind  <= kind;
      res_r.field_value <= val;
      res_r.final_res   <= done;
      res_r.status      <= status;
      res_r.consumed    <= done ? bc_inc : '0;
    end
  end

endmodule

[rtl/tpm2_nv_readpublic_response_parser.sv]
`timescale 1ns / 1ps

// Streaming parser for a TPM 2.0 NV_ReadPublic response. Response bytes come in one word per
// cycle on in_ch while ready is high, with last_byte set on the final byte; each finished header,
// public area or name size field and each policy or name byte leaves on out_ch as one word; the
// word ending a response carries final_res, a status and the byte count. A two-word queue takes
// input bytes and the parser consumes one queued byte per cycle into an output register, so the
// sustained rate is one byte per cycle while out_ch is not stalled; a byte passes the queue, then
// the output register, and a stalled output holds the queue once its two words fill. Bytes after
// an early end produce no words until the final byte, which rearms the parser.
module tpm2_nv_readpublic_response_parser import tnrp_pkg::*; #(
  parameter int unsigned POLICY_MAX = POLICY_MAX_DEF,
  parameter int unsigned NAME_MAX   = NAME_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tnrp_in_if.sink           in_ch,
  tnrp_out_if.source        out_ch
);

  qword_t in_word;
  qword_t head_word;
  logic   head_valid;
  logic   head_pop;
  res_t   res;

  assign in_word.data_byte = in_ch.data_byte;
  assign in_word.last_byte = in_ch.last_byte;

  // front: byte queue
  tnrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_word    (in_word),
    .head_valid (head_valid),
    .head_word  (head_word),
    .head_pop   (head_pop)
  );

  // back: field parser with output register
  tnrp_parser #(
    .POLICY_MAX (POLICY_MAX),
    .NAME_MAX   (NAME_MAX)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_word  (head_word),
    .head_pop   (head_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (res)
  );

  assign out_ch.field_kind  = res.field_kind;
  assign out_ch.field_value = res.field_value;
  assign out_ch.final_res   = res.final_res;
  assign out_ch.status      = res.status;
  assign out_ch.consumed    = res.consumed;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tnrp_pkg::*;

  localparam int unsigned POL_LIMIT   = POLICY_MAX_DEF;
  localparam int unsigned NAME_LIMIT  = NAME_MAX_DEF;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 5000;
  localparam int          DRAIN_GAP   = 8;
  localparam int          RANDOM_PER_PHASE = 120;

  // parse phases of the response
  typedef enum logic [3:0] {
    P_TAG, P_PSIZE, P_RC, P_PUBSZ, P_INDEX, P_ALG, P_ATTRS, P_POLSZ,
    P_POLBYTE, P_DATASZ, P_SKIP, P_NAMESZ, P_NAMEBYTE
  } parse_ph_t;

  // directed responses: rc error on the last byte, a lone byte, rc error then ignored bytes
  localparam logic [7:0] DIR_BYTES [23] = '{
    8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01,
    8'h00,
    8'h80, 8'h02, 8'h00, 8'h00, 8'h00, 8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA, 8'h55
  };
  localparam logic [22:0] DIR_LAST = (23'd1 << 9) | (23'd1 << 10) | (23'd1 << 22);

  // field tracker and store of expected words
  class nv_field_scoreboard;
    parse_ph_t   phase;
    int          fidx;
    logic [31:0] accum;
    logic [15:0] sized_left;
    logic [15:0] pub_left;
    logic [12:0] nbytes;
    bit          ended;
    res_t        expected_q[$];
    int          errors;
    int          parsed;

    function new();
      rearm();
      errors = 0;
      parsed = 0;
    endfunction

    function void rearm();
      phase      = P_TAG;
      fidx       = 0;
      accum      = '0;
      sized_left = '0;
      pub_left   = '0;
      nbytes     = '0;
      ended      = 1'b0;
    endfunction

    function void note_byte(logic [7:0] d, logic l);
      res_t want;
      bit   emit;
      bit   fin;
      bit   in_pub;
      int   need;
      want = '0;
      emit = 1'b0;
      fin  = 1'b0;
      // bytes after an early end are dropped until the final one
      if (ended) begin
        if (l) rearm();
        return;
      end
      parsed++;
      if (nbytes < COUNT_CAP) nbytes++;
      case (phase)
        P_POLBYTE, P_NAMEBYTE: begin
          emit = 1'b1;
          want.field_kind  = (phase == P_POLBYTE) ? FK_POLBYTE : FK_NAMEBYTE;
          want.field_value = {24'd0, d};
          if (phase == P_POLBYTE && pub_left != 0) pub_left--;
          if (sized_left != 0) sized_left--;
          if (sized_left == 0) begin
            if (phase == P_POLBYTE) phase = P_DATASZ;
            else fin = 1'b1;
          end
        end
        P_SKIP: begin
          if (pub_left != 0) pub_left--;
          if (pub_left == 0) phase = P_NAMESZ;
        end
        default: begin
          in_pub = (phase >= P_INDEX && phase <= P_DATASZ);
          if (in_pub && pub_left == 0) begin
            fin = 1'b1;
            want.status = ST_OVERRUN;
          end else begin
            if (in_pub) pub_left--;
            accum = {accum[23:0], d};
            fidx++;
            need = (phase == P_PSIZE || phase == P_RC || phase == P_INDEX ||
                    phase == P_ATTRS) ? 4 : 2;
            // field complete
            if (fidx == need) begin
              emit = 1'b1;
              want.field_value = accum;
              want.field_kind  = (phase == P_NAMESZ) ? FK_NAMESIZE : fkind_t'(phase);
              accum = '0;
              fidx  = 0;
              case (phase)
                P_RC: begin
                  if (want.field_value != 0) fin = 1'b1;
                  else phase = P_PUBSZ;
                end
                P_PUBSZ: begin
                  pub_left = want.field_value[15:0];
                  phase = (pub_left == 0) ? P_NAMESZ : P_INDEX;
                end
                P_POLSZ: begin
                  if (want.field_value > pub_left) begin
                    fin = 1'b1;
                    want.status = ST_OVERRUN;
                  end else if (want.field_value > POL_LIMIT) begin
                    fin = 1'b1;
                    want.status = ST_POL_LONG;
                  end else begin
                    sized_left = want.field_value[15:0];
                    phase = (sized_left == 0) ? P_DATASZ : P_POLBYTE;
                  end
                end
                P_DATASZ: phase = (pub_left == 0) ? P_NAMESZ : P_SKIP;
                P_NAMESZ: begin
                  if (want.field_value > NAME_LIMIT) begin
                    fin = 1'b1;
                    want.status = ST_NAME_LONG;
                  end else if (want.field_value == 0) begin
                    fin = 1'b1;
                  end else begin
                    sized_left = want.field_value[15:0];
                    phase = P_NAMEBYTE;
                  end
                end
                default: phase = parse_ph_t'(phase + 1);
              endcase
            end
          end
        end
      endcase
      // last byte of an unfinished parse
      if (!fin && l) begin
        fin = 1'b1;
        want.status = ST_TRUNCATED;
      end
      if (!emit && !fin) return;
      if (fin) begin
        want.final_res = 1'b1;
        want.consumed  = nbytes;
      end
      expected_q.push_back(want);
      if (fin) begin
        if (l) rearm();
        else ended = 1'b1;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected word: field_kind %0d, field_value %h", got.field_kind,
               got.field_value);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.field_kind !== want.field_kind) begin
        $error("field_kind: expected %0d, got %0d", want.field_kind, got.field_kind);
        errors++;
      end
      if (got.field_value !== want.field_value) begin
        $error("field_value: expected %h, got %h", want.field_value, got.field_value);
        errors++;
      end
      if (got.final_res !== want.final_res) begin
        $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.consumed !== want.consumed) begin
        $error("consumed: expected %0d, got %0d", want.consumed, got.consumed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   hold_reqs = 0;
  int   holds_served = 0;
  int   idle_cycles = 0;
  nv_field_scoreboard sb;

  tnrp_in_if  in_ch ();
  tnrp_out_if out_ch ();

  tpm2_nv_readpublic_response_parser #(
    .POLICY_MAX (POL_LIMIT),
    .NAME_MAX   (NAME_LIMIT)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // accepted input words
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.last_byte);
  end

  // accepted result words
  always @(posedge clk) begin : mon_out
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.field_kind  = fkind_t'(out_ch.field_kind);
      got.field_value = out_ch.field_value;
      got.final_res   = out_ch.final_res;
      got.status      = status_t'(out_ch.status);
      got.consumed    = out_ch.consumed;
      sb.check_word(got);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // offer one byte, with random idle cycles first
  task automatic send_word(input logic [7:0] d, input logic l);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait for every expected word
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // big-endian field, no last flag
  function automatic void put_field(ref logic [8:0] q[$], input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) q.push_back({v[8*i +: 8], 1'b0});
  endfunction

  // one response: well formed with random content, or broken, or noise
  function automatic void build_response(ref logic [8:0] q[$], input bit big);
    int          sel;
    int          pol_n;
    int          name_n;
    int          extra;
    int          cut;
    logic [31:0] rc;
    logic [15:0] pub;
    logic [15:0] pol_decl;
    logic [8:0]  w;
    q.delete();
    sel = big ? 60 : $urandom_range(0, 99);
    if (sel >= 95) begin
      // noise with stray last flags
      repeat ($urandom_range(1, 20))
        q.push_back({8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0)});
    end else begin
      pol_n  = ($urandom_range(0, 9) == 0) ? POL_LIMIT : $urandom_range(0, 8);
      name_n = ($urandom_range(0, 9) == 0) ? NAME_LIMIT : $urandom_range(0, 8);
      extra  = big ? 40 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
      rc = '0;
      if (sel < 8) begin
        rc = $urandom;
        if (rc == 0) rc = 32'd1;
      end
      // policy or name longer than allowed
      if (sel >= 8 && sel < 14) pol_n = $urandom_range(POL_LIMIT + 1, 200);
      if (sel >= 14 && sel < 20) name_n = $urandom_range(NAME_LIMIT + 1, 65535);
      pub = 16'(14 + pol_n + extra);
      pol_decl = 16'(pol_n);
      // fields running past the public size
      if (sel >= 20 && sel < 26) pub = 16'($urandom_range(1, 13));
      // empty public area
      if (sel >= 26 && sel < 31) pub = '0;
      // policy size past the bytes left in the area
      if (sel >= 31 && sel < 36) pol_decl = pub - 16'd12 + 16'($urandom_range(1, 40));
      put_field(q, $urandom, 2);
      put_field(q, $urandom, 4);
      put_field(q, rc, 4);
      if (rc == 0) begin
        put_field(q, pub, 2);
        if (pub != 0) begin
          put_field(q, $urandom, 4);
          put_field(q, $urandom, 2);
          put_field(q, $urandom, 4);
          put_field(q, pol_decl, 2);
          repeat ((pol_n < 70) ? pol_n : 70) put_field(q, $urandom, 1);
          put_field(q, $urandom, 2);
          repeat (extra) put_field(q, $urandom, 1);
        end
        put_field(q, name_n, 2);
        repeat ((name_n < 70) ? name_n : 70) put_field(q, $urandom, 1);
      end
      // truncated response
      if (sel >= 36 && sel < 48) begin
        cut = $urandom_range(1, q.size());
        while (q.size() > cut) void'(q.pop_back());
      end
    end
    // trailing bytes past the end of the parse
    if (!big && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_field(q, $urandom, 1);
    w = q.pop_back();
    q.push_back({w[8:1], 1'b1});
  endfunction

  // stimulus
  initial begin
    logic [8:0] rsp[$];
    int         base;
    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          snd_idle_pct  = 38;
          rcv_stall_pct = 56;
        end
        1: begin
          snd_idle_pct  = 56;
          rcv_stall_pct = 38;
        end
        default: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
      endcase
      if (phase_no == 0) begin
        foreach (DIR_BYTES[i]) send_word(DIR_BYTES[i], DIR_LAST[i]);
      end
      if (phase_no == 2) begin
        // receiver holds off while a longer response streams in
        hold_reqs++;
        build_response(rsp, 1'b1);
        foreach (rsp[i]) send_word(rsp[i][8:1], rsp[i][0]);
      end
      base = sb.parsed;
      while (sb.parsed - base < RANDOM_PER_PHASE) begin
        build_response(rsp, 1'b0);
        foreach (rsp[i]) send_word(rsp[i][8:1], rsp[i][0]);
      end
      wait_drained();
    end

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
